[sv/reverse_cuthill_mckee_ordering_macros.svh]
// Assertion macros for the reverse Cuthill-McKee ordering datapath
`ifndef REVERSE_CUTHILL_MCKEE_ORDERING_MACROS_SVH
`define REVERSE_CUTHILL_MCKEE_ORDERING_MACROS_SVH
`ifndef SYNTHESIS
`define RCM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rcm assertion failed");
`define RCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rcm assertion failed");
`else
`define RCM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/rcm_pkg.sv]
// Types and constants for the reverse Cuthill-McKee ordering block
`timescale 1ns / 1ps
package rcm_pkg;
  localparam int NV_DEFAULT = 64;
  localparam int VTX_W      = 7;
  localparam int LABEL_W    = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BASED      = 2'd2;
  localparam logic [CFG_W-1:0]     VERTEX_COUNT_RST   = 7'd64;

  typedef enum logic [4:0] {
    C_NOP, C_CAPTURE, C_RD_A, C_WR_A, C_RD_B, C_WR_B, C_ORD_INIT,
    C_DEG_RD, C_DEG_WR, C_SEED, C_SCAN_RD, C_SCAN_CMP, C_ENQ,
    C_HEAD_RD, C_ROW_RD, C_CAND, C_IDX0, C_OUT_RD, C_CLEAR
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EA_RD, S_EA_WR, S_EB_RD, S_EB_WR, S_CHK, S_DEG_RD, S_DEG_WR,
    S_BFS, S_SSCAN_RD, S_SSCAN_CMP, S_SENQ, S_ROW_RD, S_CAND, S_NCHK,
    S_NSCAN_RD, S_NSCAN_CMP, S_NENQ, S_OUT, S_CLEAR
  } state_t;

  typedef struct packed {
    logic edge_ok;
    logic sym;
    logic last;
    logic idx_last;
    logic q_empty;
    logic all_done;
    logic cand_zero;
  } stat_t;
endpackage

[sv/reverse_cuthill_mckee_ordering.sv]
// Reverse Cuthill-McKee ordering block, top level
// A last beat then runs the degree pass and the breadth-first walk over all vertices.
// Results then stream one vertex a cycle; the receiver cannot stall.
// Throughput is set by the single degree-memory port scanned once per pick.
// Reset (synchronous, rst_n low): registers to defaults, all edges dropped.
`timescale 1ns / 1ps
module reverse_cuthill_mckee_ordering #(
  parameter int MAX_VERTICES = rcm_pkg::NV_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rcm_pkg::VTX_W-1:0]     in_vertex_a,
  input  logic [rcm_pkg::VTX_W-1:0]     in_vertex_b,
  input  logic                          in_edge_valid,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  output logic [rcm_pkg::LABEL_W-1:0]   out_vertex_label,
  output logic                          out_last,
  output logic                          out_bad_edge_seen,
  input  logic                          cfg_we,
  input  logic [rcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcm_pkg::CFG_W-1:0]     cfg_data
);
  import rcm_pkg::*;

  logic [CFG_W-1:0] vertex_count_r;
  logic             symmetric_mode_r, one_based_r;
  cmd_t             cmd;
  stat_t            st;

  // Hold the configuration; writes must land only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r   <= VERTEX_COUNT_RST;
      symmetric_mode_r <= 1'b0;
      one_based_r      <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_VERTEX_COUNT)   vertex_count_r   <= cfg_data;
      if (cfg_index == REG_SYMMETRIC_MODE) symmetric_mode_r <= cfg_data[0];
      if (cfg_index == REG_ONE_BASED)      one_based_r      <= cfg_data[0];
    end
  end

  // Sequencer: one command per cycle to the datapath
  rcm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Stores and the breadth-first walk; results leave one beat a cycle
  rcm_dp #(.NV(MAX_VERTICES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .vertex_count   (vertex_count_r),
    .symmetric_mode (symmetric_mode_r),
    .one_based      (one_based_r),
    .vertex_a       (in_vertex_a),
    .vertex_b       (in_vertex_b),
    .edge_valid     (in_edge_valid),
    .last_edge      (in_last_edge),
    .out_valid      (out_valid),
    .out_label      (out_vertex_label),
    .out_last       (out_last),
    .out_bad        (out_bad_edge_seen)
  );
endmodule

[sv/rcm_ctrl.sv]
// Sequencer for loading, ordering and output of the ordering block
`timescale 1ns / 1ps
module rcm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rcm_pkg::stat_t st,
  output rcm_pkg::cmd_t  cmd,
  output logic          busy
);
  import rcm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = C_NOP;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd = C_CAPTURE;
          state_nxt = S_EA_RD;
        end
      end
      S_EA_RD: begin
        if (st.edge_ok) begin
          cmd = C_RD_A;
          state_nxt = S_EA_WR;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_EA_WR: begin
        cmd = C_WR_A;
        state_nxt = st.sym ? S_EB_RD : S_CHK;
      end
      S_EB_RD: begin
        cmd = C_RD_B;
        state_nxt = S_EB_WR;
      end
      S_EB_WR: begin
        cmd = C_WR_B;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.last) begin
          cmd = C_ORD_INIT;
          state_nxt = S_DEG_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DEG_RD: begin
        cmd = C_DEG_RD;
        state_nxt = S_DEG_WR;
      end
      S_DEG_WR: begin
        cmd = C_DEG_WR;
        state_nxt = st.idx_last ? S_BFS : S_DEG_RD;
      end
      S_BFS: begin
        priority if (!st.q_empty) begin
          cmd = C_HEAD_RD;
          state_nxt = S_ROW_RD;
        end else if (!st.all_done) begin
          cmd = C_SEED;
          state_nxt = S_SSCAN_RD;
        end else begin
          cmd = C_IDX0;
          state_nxt = S_OUT;
        end
      end
      S_SSCAN_RD: begin
        cmd = C_SCAN_RD;
        state_nxt = S_SSCAN_CMP;
      end
      S_SSCAN_CMP: begin
        cmd = C_SCAN_CMP;
        state_nxt = st.idx_last ? S_SENQ : S_SSCAN_RD;
      end
      S_SENQ: begin
        cmd = C_ENQ;
        state_nxt = S_BFS;
      end
      S_ROW_RD: begin
        cmd = C_ROW_RD;
        state_nxt = S_CAND;
      end
      S_CAND: begin
        cmd = C_CAND;
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        state_nxt = st.cand_zero ? S_BFS : S_NSCAN_RD;
      end
      S_NSCAN_RD: begin
        cmd = C_SCAN_RD;
        state_nxt = S_NSCAN_CMP;
      end
      S_NSCAN_CMP: begin
        cmd = C_SCAN_CMP;
        state_nxt = st.idx_last ? S_NENQ : S_NSCAN_RD;
      end
      S_NENQ: begin
        cmd = C_ENQ;
        state_nxt = S_NCHK;
      end
      S_OUT: begin
        cmd = C_OUT_RD;
        if (st.idx_last) state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        cmd = C_CLEAR;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[sv/rcm_dp.sv]
// Datapath of the ordering block: adjacency, degree and order stores
`timescale 1ns / 1ps
`include "reverse_cuthill_mckee_ordering_macros.svh"
module rcm_dp #(
  parameter int NV = rcm_pkg::NV_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rcm_pkg::cmd_t               cmd,
  output rcm_pkg::stat_t              st,
  input  logic [rcm_pkg::CFG_W-1:0]   vertex_count,
  input  logic                        symmetric_mode,
  input  logic                        one_based,
  input  logic [rcm_pkg::VTX_W-1:0]   vertex_a,
  input  logic [rcm_pkg::VTX_W-1:0]   vertex_b,
  input  logic                        edge_valid,
  input  logic                        last_edge,
  output logic                        out_valid,
  output logic [rcm_pkg::LABEL_W-1:0] out_label,
  output logic                        out_last,
  output logic                        out_bad
);
  import rcm_pkg::*;

  localparam int IW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);
  localparam logic [7:0] NV8 = 8'(NV);

  logic [NV-1:0] adj_mem [NV];
  logic [CW-1:0] deg_mem [NV];
  logic [IW-1:0] ord_mem [NV];

  logic [NV-1:0] adj_vld_r, adj_q_r, visited_r, cand_r;
  logic          adj_qv_r;
  logic [CW-1:0] deg_q_r, best_deg_r, head_r, tail_r, idx_r;
  logic [IW-1:0] ord_q_r, best_r, a_r, b_r;
  logic          edge_ok_r, last_r, bad_r, have_best_r;
  logic          out_valid_r, out_last_r;

  logic [CW-1:0] n;
  logic [NV-1:0] mask, row, bit_best;
  logic [7:0]    a8, b8, n8;
  logic          ok;
  logic [IW-1:0] adj_ra, adj_wa, idx_i;
  logic [NV-1:0] adj_wd;
  logic          adj_we;
  logic [CW-1:0] pop;

  always_comb begin
    priority if (vertex_count == '0)       n = CW'(1);
    else if ({1'b0, vertex_count} > NV8)   n = CW'(NV);
    else                                   n = CW'(vertex_count);
    for (int v = 0; v < NV; v++) mask[v] = (v < int'(n));
  end

  assign n8 = 8'(n);
  assign a8 = {1'b0, vertex_a};
  assign b8 = {1'b0, vertex_b};
  assign ok = one_based ? (a8 != 8'd0 && a8 <= n8 && b8 != 8'd0 && b8 <= n8)
                        : (a8 < n8 && b8 < n8);
  assign idx_i = idx_r[IW-1:0];
  assign row = adj_qv_r ? adj_q_r : '0;
  assign bit_best = NV'(1) << best_r;

  always_comb begin
    pop = '0;
    for (int v = 0; v < NV; v++) pop = pop + CW'(row[v] & mask[v]);
  end

  // Adjacency port selection
  always_comb begin
    adj_we = 1'b0;
    adj_wa = a_r;
    adj_wd = row | (NV'(1) << b_r);
    unique case (cmd)
      C_RD_B:   adj_ra = b_r;
      C_DEG_RD: adj_ra = idx_i;
      C_ROW_RD: adj_ra = ord_q_r;
      default:  adj_ra = a_r;
    endcase
    if (cmd == C_WR_A) adj_we = 1'b1;
    if (cmd == C_WR_B) begin
      adj_we = 1'b1;
      adj_wa = b_r;
      adj_wd = row | (NV'(1) << a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_q_r  <= adj_mem[adj_ra];
    adj_qv_r <= adj_vld_r[adj_ra];
    if (cmd == C_DEG_WR) deg_mem[idx_i] <= pop;
    deg_q_r <= deg_mem[idx_i];
    if (cmd == C_ENQ) ord_mem[tail_r[IW-1:0]] <= best_r;
    if (cmd == C_OUT_RD) ord_q_r <= ord_mem[IW'(n - CW'(1) - idx_r)];
    else                 ord_q_r <= ord_mem[head_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_vld_r   <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      idx_r       <= '0;
      have_best_r <= 1'b0;
      edge_ok_r   <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      out_valid_r <= (cmd == C_OUT_RD);
      if (adj_we) adj_vld_r[adj_wa] <= 1'b1;
      unique case (cmd)
        C_CAPTURE: begin
          edge_ok_r <= edge_valid & ok;
          last_r    <= last_edge;
          if (edge_valid && !ok) bad_r <= 1'b1;
        end
        C_ORD_INIT, C_IDX0: begin
          idx_r  <= '0;
          head_r <= '0;
          tail_r <= (cmd == C_IDX0) ? tail_r : '0;
        end
        C_DEG_WR, C_OUT_RD: idx_r <= idx_r + CW'(1);
        C_SEED, C_CAND: begin
          idx_r       <= '0;
          have_best_r <= 1'b0;
        end
        C_SCAN_CMP: begin
          idx_r <= idx_r + CW'(1);
          if (cand_r[idx_i] && (!have_best_r || deg_q_r < best_deg_r)) have_best_r <= 1'b1;
        end
        C_ENQ: begin
          tail_r      <= tail_r + CW'(1);
          idx_r       <= '0;
          have_best_r <= 1'b0;
        end
        C_HEAD_RD: head_r <= head_r + CW'(1);
        C_CLEAR: begin
          adj_vld_r <= '0;
          bad_r     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the walk
  always_ff @(posedge clk) begin
    if (cmd == C_CAPTURE) begin
      a_r <= one_based ? IW'(a8 - 8'd1) : IW'(a8);
      b_r <= one_based ? IW'(b8 - 8'd1) : IW'(b8);
    end
    if (cmd == C_ORD_INIT) visited_r <= '0;
    if (cmd == C_SEED) cand_r <= ~visited_r & mask;
    if (cmd == C_CAND) cand_r <= row & mask & ~visited_r;
    if (cmd == C_SCAN_CMP && cand_r[idx_i] && (!have_best_r || deg_q_r < best_deg_r)) begin
      best_r     <= idx_i;
      best_deg_r <= deg_q_r;
    end
    if (cmd == C_ENQ) begin
      visited_r <= visited_r | bit_best;
      cand_r    <= cand_r & ~bit_best;
    end
    out_last_r <= (idx_r == n - CW'(1));
  end

  assign st.edge_ok   = edge_ok_r;
  assign st.sym       = symmetric_mode;
  assign st.last      = last_r;
  assign st.idx_last  = (idx_r == n - CW'(1));
  assign st.q_empty   = (head_r == tail_r);
  assign st.all_done  = (tail_r == n);
  assign st.cand_zero = (cand_r == '0);

  assign out_valid = out_valid_r;
  assign out_label = LABEL_W'(ord_q_r);
  assign out_last  = out_last_r;
  assign out_bad   = bad_r;

  `RCM_ASSERT_SAME(a_enq_has_best, clk, rst_n, cmd == C_ENQ, have_best_r)
  `RCM_ASSERT_NEXT(a_enq_tail_step, clk, rst_n, cmd == C_ENQ, tail_r == $past(tail_r) + CW'(1))
  `RCM_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_valid_r && out_last_r, !out_valid_r)
endmodule

[verif/reverse_cuthill_mckee_ordering_checker.sv]
// Ordering checker: predicts the permutation for each graph and compares every result beat
`timescale 1ns / 1ps
module reverse_cuthill_mckee_ordering_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rcm_pkg::VTX_W-1:0]     in_vertex_a,
  input  logic [rcm_pkg::VTX_W-1:0]     in_vertex_b,
  input  logic                          in_edge_valid,
  input  logic                          in_last_edge,
  input  logic                          out_valid,
  input  logic [rcm_pkg::LABEL_W-1:0]   out_vertex_label,
  input  logic                          out_last,
  input  logic                          out_bad_edge_seen,
  input  logic                          cfg_we,
  input  logic [rcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcm_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            vertices_checked
);
  import rcm_pkg::*;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               fin;
    logic               bad;
  } perm_entry_t;

  perm_entry_t perm_q[$];

  logic [CFG_W-1:0] vcount_reg;
  logic             sym_reg;
  logic             one_based_reg;
  logic [63:0]      adj_rows [64];
  logic [6:0]       degree [64];
  logic             bad_seen;

  assign pending = perm_q.size();

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int clamp_count();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > 64) return 64;
    return int'(vcount_reg);
  endfunction

  function automatic logic [63:0] vertex_mask(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Lowest degree among the candidates, lower label on a tie
  function automatic int least_degree(logic [63:0] cand, int n);
    int best;
    int best_deg;
    best = 0;
    best_deg = 1000;
    for (int v = 0; v < n; v++)
      if (cand[v] && degree[v] < best_deg) begin
        best_deg = degree[v];
        best = v;
      end
    return best;
  endfunction

  task automatic store_edge(int a, int b);
    if (!adj_rows[a][b]) begin
      adj_rows[a][b] = 1'b1;
      degree[a] = degree[a] + 7'd1;
    end
  endtask

  task automatic clear_graph();
    for (int i = 0; i < 64; i++) begin
      adj_rows[i] = '0;
      degree[i] = '0;
    end
    bad_seen = 1'b0;
  endtask

  // Breadth-first walk from least-degree seeds, then queue the visit order reversed
  task automatic order_and_expect(int n);
    logic [63:0] mask;
    logic [63:0] seen;
    logic [63:0] cand;
    int          visit [64];
    int          head;
    int          tail;
    int          cur;
    int          w;
    perm_entry_t e;
    mask = vertex_mask(n);
    for (int v = 0; v < n; v++) degree[v] = 7'($countones(adj_rows[v] & mask));
    seen = '0;
    head = 0;
    tail = 0;
    while (tail < n) begin
      w = least_degree(~seen & mask, n);
      seen[w] = 1'b1;
      visit[tail] = w;
      tail++;
      while (head < tail) begin
        cur = visit[head];
        head++;
        cand = adj_rows[cur] & mask & ~seen;
        while (cand != 0) begin
          w = least_degree(cand, n);
          seen[w] = 1'b1;
          visit[tail] = w;
          tail++;
          cand[w] = 1'b0;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      e.label = LABEL_W'(visit[n - 1 - k]);
      e.fin   = (k == n - 1);
      e.bad   = bad_seen;
      perm_q.insert(perm_q.size(), e);
    end
    clear_graph();
  endtask

  always @(posedge clk) begin
    int          n;
    int          a;
    int          b;
    logic        ok;
    perm_entry_t want;
    if (!rst_n) begin
      vcount_reg    <= VERTEX_COUNT_RST;
      sym_reg       <= 1'b0;
      one_based_reg <= 1'b0;
      clear_graph();
      perm_q.delete();
      fail_count = 0;
      vertices_checked = 0;
    end else begin
      // Compare the result beat first; it belongs to an earlier graph
      if (out_valid) begin
        if (perm_q.size() == 0) begin
          $display("[%0t] result beat with nothing expected (label %0d)", $time,
                   out_vertex_label);
          fail_count++;
        end else begin
          want = perm_q.pop_front();
          vertices_checked++;
          if (out_vertex_label !== want.label) report("vertex_label", out_vertex_label,
                                                      want.label);
          if (out_last !== want.fin) report("last", out_last, want.fin);
          if (out_bad_edge_seen !== want.bad) report("bad_edge_seen", out_bad_edge_seen,
                                                     want.bad);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_VERTEX_COUNT:   vcount_reg    <= cfg_data;
          REG_SYMMETRIC_MODE: sym_reg       <= cfg_data[0];
          REG_ONE_BASED:      one_based_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        n = clamp_count();
        a = int'(in_vertex_a);
        b = int'(in_vertex_b);
        if (in_edge_valid) begin
          if (one_based_reg) begin
            ok = (a >= 1 && a <= n && b >= 1 && b <= n);
            a--;
            b--;
          end else begin
            ok = (a < n && b < n);
          end
          if (!ok) bad_seen = 1'b1;
          else begin
            store_edge(a, b);
            if (sym_reg) store_edge(b, a);
          end
        end
        if (in_last_edge) order_and_expect(n);
      end
    end
  end

endmodule

[verif/reverse_cuthill_mckee_ordering_test.sv]
// Testbench top for the reverse Cuthill-McKee ordering block: stimulus and verdict
`timescale 1ns / 1ps
module reverse_cuthill_mckee_ordering_test;
  import rcm_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [VTX_W-1:0]     in_vertex_a = '0;
  logic [VTX_W-1:0]     in_vertex_b = '0;
  logic                 in_edge_valid = 1'b0;
  logic                 in_last_edge = 1'b0;
  logic                 out_valid;
  logic [LABEL_W-1:0]   out_vertex_label;
  logic                 out_last;
  logic                 out_bad_edge_seen;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VERTEX_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;
  int vertices_checked;
  int edge_beats;
  int graphs_done;
  bit steady_window;   // while set, send_beat inserts no random idle gaps

  always #2 clk = ~clk;

  reverse_cuthill_mckee_ordering u_dut (
    .clk, .rst_n, .start, .busy,
    .in_vertex_a, .in_vertex_b, .in_edge_valid, .in_last_edge,
    .out_valid, .out_vertex_label, .out_last, .out_bad_edge_seen,
    .cfg_we, .cfg_index, .cfg_data
  );

  reverse_cuthill_mckee_ordering_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_vertex_a, .in_vertex_b, .in_edge_valid, .in_last_edge,
    .out_valid, .out_vertex_label, .out_last, .out_bad_edge_seen,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .vertices_checked
  );

  // Send one beat. Idle first at random, then hold start until an edge with busy low.
  // busy is sampled at the falling edge, so the decision never races the DUT.
  // start stays high after the accepting edge: the caller sends again or drains at once.
  task automatic send_beat(int a, int b, bit ev, bit le);
    if (!steady_window && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start         <= 1'b1;
    in_vertex_a   <= VTX_W'(a);
    in_vertex_b   <= VTX_W'(b);
    in_edge_valid <= ev;
    in_last_edge  <= le;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (ev || le) edge_beats++;
    if (le) graphs_done++;
  endtask

  // Drop start and wait for all expected vertices plus the block's clearing tail
  task automatic drain();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0 && !busy) break;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_mode(int n, bit sym, bit ob);
    drain();
    write_reg(REG_VERTEX_COUNT, n);
    write_reg(REG_SYMMETRIC_MODE, sym);
    write_reg(REG_ONE_BASED, ob);
  endtask

  // Pick one endpoint: in range for the numbering base, or out of range when asked
  function automatic int pick_end(int n, bit ob, bit wild);
    if (wild) begin
      if (ob) return ($urandom_range(1) != 0) ? 0 : $urandom_range(127, n + 1);
      return $urandom_range(127, n);
    end
    return ob ? $urandom_range(n, 1) : $urandom_range(n - 1, 0);
  endfunction

  // One random graph: mostly well-formed edges, a few dropped ones and empty beats
  task automatic random_graph(int n, int edges);
    bit sym;
    bit ob;
    bit wild;
    sym = 1'($urandom_range(1));
    ob  = 1'($urandom_range(1));
    set_mode(n, sym, ob);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(99) < 8) send_beat($urandom_range(127), $urandom_range(127), 0, 0);
      wild = ($urandom_range(99) < 10);
      send_beat(pick_end(n, ob, wild), pick_end(n, ob, 1'b0), 1'b1, 1'b0);
    end
    wild = ($urandom_range(99) < 10);
    send_beat(pick_end(n, ob, wild), pick_end(n, ob, 1'b0), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    edge_beats = 0;
    graphs_done = 0;
    steady_window = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default registers, full 64 vertices, extremes, duplicates, self loop, bad edge
    drain();
    send_beat(0, 63, 1, 0);
    send_beat(0, 63, 1, 0);
    send_beat(63, 63, 1, 0);
    send_beat(64, 5, 1, 0);
    send_beat(127, 127, 0, 0);
    send_beat(5, 0, 1, 1);

    // Single vertex; a count of zero acts as one
    set_mode(0, 0, 0);
    send_beat(0, 0, 1, 1);
    set_mode(1, 1, 1);
    send_beat(1, 1, 1, 0);
    send_beat(0, 2, 1, 1);

    // Count above the limit acts as 64; one-based endpoints 1 and 64 are fine
    set_mode(127, 1, 1);
    send_beat(1, 64, 1, 0);
    send_beat(64, 32, 1, 0);
    send_beat(65, 3, 1, 0);
    send_beat(0, 0, 0, 1);

    // Load eight vertices, then shrink to four before ordering
    set_mode(8, 1, 0);
    send_beat(0, 7, 1, 0);
    send_beat(1, 2, 1, 0);
    send_beat(2, 3, 1, 0);
    send_beat(6, 5, 1, 0);
    drain();
    write_reg(REG_VERTEX_COUNT, 4);
    send_beat(3, 3, 1, 1);

    // Random graphs: mostly small, occasionally at full size
    while (edge_beats < 105) begin
      steady_window = (edge_beats > 50 && edge_beats < 80);
      if ($urandom_range(99) < 8) random_graph(64, $urandom_range(20, 4));
      else random_graph($urandom_range(12, 2), $urandom_range(12, 0));
    end
    steady_window = 1'b0;

    drain();
    $display("covered %0d graphs from %0d edge beats, %0d permutation vertices compared",
             graphs_done, edge_beats, vertices_checked);
    $display("including symmetric and one-based loading, dropped edges and count extremes");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20000000;
    $display("timeout with %0d vertices still expected", pending);
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rcm_pkg.sv
sv/rcm_ctrl.sv
sv/rcm_dp.sv
sv/reverse_cuthill_mckee_ordering.sv
verif/reverse_cuthill_mckee_ordering_checker.sv
verif/reverse_cuthill_mckee_ordering_test.sv
